FILE: rtl/mvavg_pkg.sv
// ----------------------------------------------------------------------------
// mvavg_pkg
// Shared types and constants of the moving average filter.
// ----------------------------------------------------------------------------
`default_nettype none

package mvavg_pkg;

   // fixed field widths
   localparam int unsigned SUM_BITS      = 24;
   localparam int unsigned AVG_BITS      = 16;
   localparam int unsigned WIN_BITS      = 9;
   localparam int unsigned CSR_DATA_BITS = 32;
   localparam int unsigned CSR_ADDR_BITS = 3;

   // request commands
   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_CLEAR  = 1'b1;

   // register index, taken from paddr[2]
   localparam logic CSR_IDX_WINDOW = 1'b0;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_SETUP,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

endpackage

`default_nettype wire

FILE: rtl/mvavg_if.sv
// ----------------------------------------------------------------------------
// mvavg channel interfaces
// Valid/ready channels for requests (command and sample) and results.
// ----------------------------------------------------------------------------
`default_nettype none

interface mvavg_req_if #(
   parameter int unsigned SAMPLE_BITS = 16
);
   logic                          valid;
   logic                          ready;
   logic                          cmd;
   logic signed [SAMPLE_BITS-1:0] sample;

   modport source (output valid, output cmd, output sample, input ready);
   modport sink   (input valid, input cmd, input sample, output ready);
endinterface

interface mvavg_rsp_if;
   import mvavg_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [AVG_BITS-1:0] average;

   modport source (output valid, output average, input ready);
   modport sink   (input valid, input average, output ready);
endinterface

`default_nettype wire

FILE: rtl/moving_average_filter.sv
// ----------------------------------------------------------------------------
// moving_average_filter
// Running average over a ring of the last window_size signed samples.
// ----------------------------------------------------------------------------
// Each sample transfer writes the sample into a ring buffer, updates a 24-bit
// running sum and returns the sum divided by the number of samples held
// (fill count until the window is full, window_size after), truncated toward
// zero. After a sample transfer the block steps through update (sum and
// ring), setup of the divider, the restoring divider that produces one
// quotient bit per cycle, and finish, which loads the output register and
// waits only while the previous result is still held there. No new request
// is taken until the block is back in idle. A clear command is taken in idle
// and returns nothing.
// Writing window_size (register 0, byte address 0; 0 acts as 1, values above
// WINDOW_MAX act as WINDOW_MAX) also empties the filter. The ring is never
// read before it is written since the last clear, so it needs no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module moving_average_filter #(
   parameter int unsigned WINDOW_MAX  = 256,
   parameter int unsigned SAMPLE_BITS = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   mvavg_req_if.sink                                req_ch,
   mvavg_rsp_if.source                              rsp_ch,
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [mvavg_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  wire logic [mvavg_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic      [mvavg_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                                     csr_pready
);
   import mvavg_pkg::*;

   localparam int unsigned AW        = $clog2(WINDOW_MAX);
   localparam int unsigned PW        = (AW + 1 > WIN_BITS) ? AW + 1 : WIN_BITS;
   localparam int unsigned EXT_BITS  = (SAMPLE_BITS > SUM_BITS) ? SAMPLE_BITS : SUM_BITS;
   localparam int unsigned WIN_CLAMP = (WINDOW_MAX > 511) ? 511 : WINDOW_MAX;
   localparam int unsigned WIN_RESET = (WINDOW_MAX > 256) ? 256 : WINDOW_MAX;
   localparam int unsigned CNT_BITS  = $clog2(SUM_BITS);

   // ring buffer
   logic [SAMPLE_BITS-1:0] sample_mem [WINDOW_MAX];
   logic [SAMPLE_BITS-1:0] rd_data_ff;

   state_type state_ff, state_in;

   logic [WIN_BITS-1:0]     window_ff, window_in;
   logic [AW-1:0]           wpos_ff, wpos_in;
   logic [SUM_BITS-1:0]     sum_ff, sum_in;
   logic [WIN_BITS-1:0]     fill_ff, fill_in;
   logic [SAMPLE_BITS-1:0]  sample_ff;

   // divider state
   logic [SUM_BITS-1:0]     dq_ff, dq_in;
   logic [WIN_BITS-1:0]     rem_ff, rem_in;
   logic [CNT_BITS-1:0]     cnt_ff, cnt_in;
   logic                    neg_ff, neg_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [AVG_BITS-1:0]     avg_ff, avg_in;

   // controls from the sequencer
   logic req_ready;
   logic do_capture;
   logic do_clear;
   logic do_update;
   logic do_setup;
   logic do_step;
   logic do_finish;

   logic req_xfer;
   logic csr_write;
   logic csr_win_write;

   // datapath intermediates
   logic                    full;
   logic signed [EXT_BITS-1:0] new_wide;
   logic signed [EXT_BITS-1:0] old_wide;
   logic [SUM_BITS-1:0]     old_val;
   logic [PW-1:0]           pos_next;
   logic [WIN_BITS-1:0]     win_wdata;
   logic [WIN_BITS:0]       rem_sh;
   logic [WIN_BITS:0]       rem_diff;
   logic                    rem_ge;
   logic [SUM_BITS-1:0]     quot_signed;

   assign req_xfer      = req_ch.valid && req_ready;
   assign csr_write     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_win_write = csr_write && (csr_paddr[2:2] == CSR_IDX_WINDOW);
   assign csr_pready    = 1'b1;

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2:2] == CSR_IDX_WINDOW) begin
         csr_prdata = CSR_DATA_BITS'(window_ff);
      end
   end

   // ------------------------------------------------------------------
   // sequencer
   // ------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer && req_ch.cmd == CMD_SAMPLE) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: state_in = ST_SETUP;
         ST_SETUP:  state_in = ST_DIVIDE;
         ST_DIVIDE: begin
            if (cnt_ff == CNT_BITS'(SUM_BITS - 1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready  = 1'b0;
      do_capture = 1'b0;
      do_clear   = 1'b0;
      do_update  = 1'b0;
      do_setup   = 1'b0;
      do_step    = 1'b0;
      do_finish  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            do_capture = req_ch.valid && req_ch.cmd == CMD_SAMPLE;
            do_clear   = req_ch.valid && req_ch.cmd == CMD_CLEAR;
         end
         ST_UPDATE: do_update = 1'b1;
         ST_SETUP:  do_setup  = 1'b1;
         ST_DIVIDE: do_step   = 1'b1;
         ST_FINISH: do_finish = !rsp_valid_ff || rsp_ch.ready;
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   assign req_ch.ready = req_ready;

   // ------------------------------------------------------------------
   // ring and running sum
   // ------------------------------------------------------------------
   assign full     = fill_ff >= window_ff;
   assign new_wide = EXT_BITS'(signed'(sample_ff));
   assign old_wide = EXT_BITS'(signed'(rd_data_ff));
   assign old_val  = full ? old_wide[SUM_BITS-1:0] : '0;
   assign pos_next = PW'(wpos_ff) + PW'(1);

   always_comb begin
      win_wdata = csr_pwdata[WIN_BITS-1:0];
      if (win_wdata == '0) begin
         win_wdata = WIN_BITS'(1);
      end else if (32'(win_wdata) > 32'(WIN_CLAMP)) begin
         win_wdata = WIN_BITS'(WIN_CLAMP);
      end
   end

   always_comb begin
      window_in = window_ff;
      wpos_in   = wpos_ff;
      sum_in    = sum_ff;
      fill_in   = fill_ff;
      if (csr_win_write) begin
         window_in = win_wdata;
         wpos_in   = '0;
         sum_in    = '0;
         fill_in   = '0;
      end else if (do_clear) begin
         wpos_in = '0;
         sum_in  = '0;
         fill_in = '0;
      end else if (do_update) begin
         sum_in = sum_ff - old_val + new_wide[SUM_BITS-1:0];
         if (pos_next >= PW'(window_ff)) begin
            wpos_in = '0;
         end else begin
            wpos_in = pos_next[AW-1:0];
         end
         if (!full) begin
            fill_in = fill_ff + WIN_BITS'(1);
         end
      end
   end

   // ------------------------------------------------------------------
   // restoring divider, one quotient bit per cycle
   // ------------------------------------------------------------------
   assign rem_sh   = {rem_ff, dq_ff[SUM_BITS-1]};
   assign rem_diff = rem_sh - {1'b0, fill_ff};
   assign rem_ge   = rem_sh >= {1'b0, fill_ff};

   always_comb begin
      dq_in  = dq_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      neg_in = neg_ff;
      if (do_setup) begin
         neg_in = sum_ff[SUM_BITS-1];
         dq_in  = sum_ff[SUM_BITS-1] ? (~sum_ff + SUM_BITS'(1)) : sum_ff;
         rem_in = '0;
         cnt_in = '0;
      end else if (do_step) begin
         rem_in = rem_ge ? rem_diff[WIN_BITS-1:0] : rem_sh[WIN_BITS-1:0];
         dq_in  = {dq_ff[SUM_BITS-2:0], rem_ge};
         cnt_in = cnt_ff + CNT_BITS'(1);
      end
   end

   // ------------------------------------------------------------------
   // output register
   // ------------------------------------------------------------------
   assign quot_signed  = neg_ff ? (~dq_ff + SUM_BITS'(1)) : dq_ff;
   assign avg_in       = do_finish ? quot_signed[AVG_BITS-1:0] : avg_ff;
   assign rsp_valid_in = do_finish || (rsp_valid_ff && !rsp_ch.ready);

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.average = avg_ff;

   // ------------------------------------------------------------------
   // registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         window_ff    <= WIN_BITS'(WIN_RESET);
         wpos_ff      <= '0;
         sum_ff       <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         window_ff    <= window_in;
         wpos_ff      <= wpos_in;
         sum_ff       <= sum_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dq_ff  <= dq_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
      avg_ff <= avg_in;
      if (do_capture) begin
         sample_ff <= req_ch.sample;
      end
   end

   // ring memory, read of the slot about to be replaced is registered
   always_ff @(posedge clock) begin
      rd_data_ff <= sample_mem[wpos_ff];
      if (do_update) begin
         sample_mem[wpos_ff] <= sample_ff;
      end
   end

endmodule

`default_nettype wire

FILE: tb/sv/moving_average_filter_test.sv
// ----------------------------------------------------------------------------
// moving_average_filter_test
// Self-checking bench for the moving average filter: requests and results
// go over valid/ready channels, window_size goes over the csr port. A local
// ring, sum and fill count predict each average, and the averages that come
// back are compared in order against it. The run has directed cases, random
// segments over several window sizes and idling patterns, a long receiver
// hold-off and a write to an unused register.
// ----------------------------------------------------------------------------
`default_nettype none

module moving_average_filter_test;
   timeunit 1ns;
   timeprecision 1ps;

   import mvavg_pkg::*;

   localparam int WINDOW_MAX   = 256;
   localparam int SAMPLE_BITS  = 16;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int SETTLE       = 40;
   localparam int HOLD_CYCLES  = 800;
   localparam int MAX_REPORTS  = 10;

   // no register sits at this index
   localparam logic CSR_IDX_UNUSED = 1'b1;

   typedef struct packed {
      logic                   cmd;
      logic [SAMPLE_BITS-1:0] sample;
   } filter_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                     csr_psel;
   logic                     csr_penable;
   logic                     csr_pwrite;
   logic [CSR_ADDR_BITS-1:0] csr_paddr;
   logic [CSR_DATA_BITS-1:0] csr_pwdata;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   mvavg_req_if #(.SAMPLE_BITS(SAMPLE_BITS)) req_ch ();
   mvavg_rsp_if rsp_ch ();

   moving_average_filter #(
      .WINDOW_MAX (WINDOW_MAX),
      .SAMPLE_BITS(SAMPLE_BITS)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .rsp_ch     (rsp_ch),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   always #2 clock = ~clock;

   // stimulus and expectations
   filter_item_type    pending_items[$];
   logic signed [15:0] expected_avgs[$];
   logic               req_taken = 1'b0;
   int                 error_count = 0;
   int                 cycle_count = 0;
   int                 send_idle_pct = 0;
   int                 recv_stall_pct = 0;
   int                 hold_left = 0;
   int                 holds_asked = 0;
   int                 holds_served = 0;

   // filter state as predicted
   logic signed [SAMPLE_BITS-1:0] ring_store[WINDOW_MAX];
   logic [7:0]                    wr_pos;
   logic signed [SUM_BITS-1:0]    run_sum;
   logic [WIN_BITS-1:0]           fill_cnt;
   logic [WIN_BITS-1:0]           win_size;

   function automatic void empty_window();
      wr_pos   = '0;
      run_sum  = '0;
      fill_cnt = '0;
   endfunction

   function automatic logic signed [AVG_BITS-1:0] advance_window(
      input logic signed [SAMPLE_BITS-1:0] s
   );
      logic signed [SUM_BITS-1:0] leaving;
      logic [WIN_BITS-1:0]        next_pos;
      int                         num;
      int                         den;
      int                         quotient;
      // slot only holds a live sample once the window is full
      if (fill_cnt >= win_size) begin
         leaving = SUM_BITS'(ring_store[wr_pos]);
      end else begin
         leaving = '0;
      end
      ring_store[wr_pos] = s;
      run_sum = run_sum - leaving + SUM_BITS'(s);
      next_pos = {1'b0, wr_pos} + 9'd1;
      wr_pos = (next_pos >= win_size) ? '0 : next_pos[7:0];
      if (fill_cnt < win_size) begin
         fill_cnt = fill_cnt + 9'd1;
      end
      num = int'(run_sum);
      den = int'(fill_cnt);
      quotient = num / den;
      return quotient[AVG_BITS-1:0];
   endfunction

   task automatic note_mismatch(input string what, input int want, input int got);
      error_count++;
      if (error_count <= MAX_REPORTS) begin
         $display("mismatch on %s: expected %0d, got %0d at %0t", what, want, got, $time);
      end
   endtask

   // request driver
   always @(negedge clock) begin : req_driver
      filter_item_type next_item;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_taken) begin
         if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            next_item = pending_items.pop_front();
            req_ch.valid  <= 1'b1;
            req_ch.cmd    <= next_item.cmd;
            req_ch.sample <= next_item.sample;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // long receiver hold-off, started by the stimulus
   always @(negedge clock) begin
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (holds_served != holds_asked) begin
         hold_left    <= HOLD_CYCLES;
         holds_served <= holds_served + 1;
      end
   end

   always @(negedge clock) begin
      rsp_ch.ready <= !reset && hold_left == 0 && $urandom_range(99) >= recv_stall_pct;
   end

   // watches both channels: predicts on each request transfer, checks each result
   always @(posedge clock) begin : channel_monitor
      logic signed [AVG_BITS-1:0] want;
      req_taken <= !reset && req_ch.valid && req_ch.ready;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            if (req_ch.cmd == CMD_CLEAR) begin
               empty_window();
            end else begin
               expected_avgs.push_back(advance_window(req_ch.sample));
            end
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_avgs.size() == 0) begin
               error_count++;
               if (error_count <= MAX_REPORTS) begin
                  $display("average %0d arrived with none expected at %0t",
                           rsp_ch.average, $time);
               end
            end else begin
               want = expected_avgs.pop_front();
               if (rsp_ch.average !== want) begin
                  note_mismatch("average", int'(want), int'(rsp_ch.average));
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic csr_access(
      input  logic                     wr,
      input  logic                     idx,
      input  logic [CSR_DATA_BITS-1:0] wdata,
      output logic [CSR_DATA_BITS-1:0] rdata
   );
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic set_window(input logic [WIN_BITS-1:0] raw);
      logic [CSR_DATA_BITS-1:0] wdata;
      logic [CSR_DATA_BITS-1:0] rdata;
      logic [WIN_BITS-1:0]      eff;
      // upper data bits are don't-care, so make them noise
      wdata = $urandom();
      wdata[WIN_BITS-1:0] = raw;
      csr_access(1'b1, CSR_IDX_WINDOW, wdata, rdata);
      eff = (raw == '0) ? 9'd1 : (int'(raw) > WINDOW_MAX) ? 9'(WINDOW_MAX) : raw;
      win_size = eff;
      empty_window();
      if (raw == eff) begin
         csr_access(1'b0, CSR_IDX_WINDOW, '0, rdata);
         if (rdata[WIN_BITS-1:0] != eff) begin
            note_mismatch("window_size readback", int'(eff), int'(rdata[WIN_BITS-1:0]));
         end
      end
   endtask

   task automatic set_idling(input int sender, input int receiver);
      send_idle_pct  = sender;
      recv_stall_pct = receiver;
   endtask

   task automatic queue_item(input logic cmd, input logic [SAMPLE_BITS-1:0] sample);
      filter_item_type item;
      item.cmd    = cmd;
      item.sample = sample;
      pending_items.push_back(item);
   endtask

   function automatic logic [SAMPLE_BITS-1:0] pick_sample(input int full_scale_pct);
      int roll;
      int near_zero;
      roll = $urandom_range(99);
      if (roll < full_scale_pct) begin
         return $urandom_range(1) ? 16'h7fff : 16'h8000;
      end else if (roll < full_scale_pct + (100 - full_scale_pct) / 4) begin
         near_zero = $urandom_range(15);
         near_zero = near_zero - 8;
         return near_zero[SAMPLE_BITS-1:0];
      end
      return SAMPLE_BITS'($urandom());
   endfunction

   task automatic queue_random(input int count, input int clear_pct, input int full_scale_pct);
      repeat (count) begin
         if ($urandom_range(99) < clear_pct) begin
            queue_item(CMD_CLEAR, SAMPLE_BITS'($urandom()));
         end else begin
            queue_item(CMD_SAMPLE, pick_sample(full_scale_pct));
         end
      end
   endtask

   // sampled at the rising edge so the driver's falling-edge updates are settled
   task automatic wait_drained();
      do @(posedge clock);
      while (pending_items.size() != 0 || req_ch.valid || expected_avgs.size() != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   initial begin : stimulus
      logic [CSR_DATA_BITS-1:0] rdata;
      req_ch.valid  = 1'b0;
      req_ch.cmd    = CMD_SAMPLE;
      req_ch.sample = '0;
      rsp_ch.ready  = 1'b0;
      csr_psel      = 1'b0;
      csr_penable   = 1'b0;
      csr_pwrite    = 1'b0;
      csr_paddr     = '0;
      csr_pwdata    = '0;
      win_size      = 9'(WINDOW_MAX);
      empty_window();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      csr_access(1'b0, CSR_IDX_WINDOW, '0, rdata);
      if (rdata[WIN_BITS-1:0] != 9'(WINDOW_MAX)) begin
         note_mismatch("window_size after reset", WINDOW_MAX, int'(rdata[WIN_BITS-1:0]));
      end

      // directed: partial window at full scale and alternating bit patterns
      queue_item(CMD_SAMPLE, 16'h7fff);
      queue_item(CMD_SAMPLE, 16'h8000);
      queue_item(CMD_SAMPLE, 16'h0000);
      queue_item(CMD_SAMPLE, 16'hffff);
      queue_item(CMD_SAMPLE, 16'h0001);
      queue_item(CMD_SAMPLE, 16'h5555);
      queue_item(CMD_SAMPLE, 16'haaaa);
      queue_item(CMD_CLEAR, 16'h1234);
      // negative quotients truncate toward zero
      queue_item(CMD_SAMPLE, -16'sd7);
      queue_item(CMD_SAMPLE, 16'sd2);
      queue_item(CMD_SAMPLE, -16'sd1);
      wait_drained();

      // tiny window: full after two, then oldest sample drops out
      set_window(9'd2);
      queue_item(CMD_SAMPLE, 16'h7fff);
      queue_item(CMD_SAMPLE, 16'h7fff);
      queue_item(CMD_SAMPLE, 16'h8000);
      queue_item(CMD_SAMPLE, 16'h8000);
      queue_item(CMD_SAMPLE, 16'sd3);
      queue_item(CMD_SAMPLE, -16'sd4);
      queue_item(CMD_CLEAR, 16'hffff);
      queue_item(CMD_SAMPLE, 16'h8000);
      wait_drained();

      // zero acts as a window of one
      set_window(9'd0);
      set_idling(0, 0);
      queue_random(150, 3, 20);
      wait_drained();

      // above the maximum acts as the maximum; drive the sum to its negative limit
      set_window(9'd511);
      set_idling(58, 0);
      repeat (260) queue_item(CMD_SAMPLE, 16'h8000);
      queue_random(160, 1, 30);
      wait_drained();

      set_window(9'($urandom_range(2, 16)));
      set_idling(0, 58);
      queue_random(200, 3, 20);
      wait_drained();

      set_window(9'd3);
      set_idling(37, 37);
      queue_random(150, 3, 20);
      wait_drained();

      // writes to an unused index must leave the running window alone
      csr_access(1'b1, CSR_IDX_UNUSED, 32'h0000_0001, rdata);
      queue_random(20, 0, 20);
      wait_drained();

      // receiver holds off while the sender keeps offering
      set_window(9'd5);
      set_idling(0, 0);
      holds_asked++;
      queue_random(60, 3, 20);
      wait_drained();

      set_window(9'($urandom_range(17, 255)));
      set_idling(58, 58);
      queue_random(300, 2, 20);
      wait_drained();

      // exact maximum, pushing toward the positive limit
      set_window(9'(WINDOW_MAX));
      set_idling(37, 37);
      repeat (260) queue_item(CMD_SAMPLE, 16'h7fff);
      queue_random(40, 1, 50);
      wait_drained();

      set_window(9'd1);
      set_idling(0, 0);
      queue_random(200, 4, 20);
      wait_drained();

      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire
